// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the hdl folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds on the same edge as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent holds on the edge after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/hsi_pkg.sv
// ---------------------------------------------------------------------------
// HSI to RGB package
// Constants, sector codes and the elaboration-time ratio table generator.
// ---------------------------------------------------------------------------
package hsi_pkg;

	localparam int RATIO_FRAC_BITS_DEF = 14;
	localparam int SECTOR_DEG = 120;
	localparam int FULL_TURN = 360;
	localparam int SAT_ONE = 256;
	localparam int COS_TERMS = 10;
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint unsigned ONE_Q28 = 64'd268435456;

	typedef enum logic [1:0] {
		SECT_RED   = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE  = 2'd2
	} sector_t;

	// bitwise long division, elaboration only
	function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// cosine of whole degrees in Q28 by truncated Taylor series
	function automatic longint cos_q28(int deg);
		longint unsigned a;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		a = (longint'(unsigned'(deg)) * PI_Q30) / 720;
		x2 = (a * a) >> 28;
		term = ONE_Q28;
		sum = longint'(ONE_Q28);
		for (int k = 1; k <= COS_TERMS; k++) begin
			term = (term * x2) >> 28;
			term = udiv(term, longint'((2 * k - 1) * (2 * k)));
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return sum;
	endfunction

	// cos(off) / cos(60 - off) in Q(frac), truncated toward zero
	function automatic longint ratio_entry(int off, int frac);
		int other;
		longint num;
		longint den;
		longint unsigned mag;
		other = (off <= 60) ? (60 - off) : (off - 60);
		num = cos_q28(off) * (longint'(1) << frac);
		den = cos_q28(other);
		if (den <= 0)
			return 0;
		if (num < 0) begin
			mag = udiv(longint'(-num), longint'(den));
			return -longint'(mag);
		end
		mag = udiv(longint'(num), longint'(den));
		return longint'(mag);
	endfunction

endpackage

// File: hdl/hsi_to_rgb_converter.sv
// ---------------------------------------------------------------------------
// HSI to RGB converter
// Four-stage pipeline from hue, saturation and intensity to 8-bit RGB.
// ---------------------------------------------------------------------------
// One pixel per clock is accepted and one RGB triple leaves per clock unless
// the output stalls. Stage one wraps hue, clamps saturation and picks the
// sector, stage two reads the ratio table and forms S*ratio and I*(1-S), stage
// three forms the leading channel with the third multiplier, stage four forms
// the third channel, clamps all three and holds the result in the output
// register. Backpressure on the output stalls only the stages that hold data,
// so bubbles are filled while the sink waits.
`include "assert_macros.svh"

module hsi_to_rgb_converter #(
	parameter int RATIO_FRAC_BITS = hsi_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // hue_degrees[8:0], saturation[17:9], intensity[25:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

	localparam int RW = RATIO_FRAC_BITS + 3;
	localparam int SRW = RW + 10;
	localparam int FW = SRW + 9;
	localparam int CSH = RATIO_FRAC_BITS + 8;
	localparam int TAB_N = hsi_pkg::SECTOR_DEG;

	logic signed [RW-1:0] ratio_rom [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_ratio
		localparam logic signed [RW-1:0] ENTRY =
			RW'(hsi_pkg::ratio_entry(g, RATIO_FRAC_BITS));
		assign ratio_rom[g] = ENTRY;
	end

	logic rdy1, rdy2, rdy3, rdy4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	assign rdy4 = !vld_s4 || m_tready;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	// stage 1: wrap hue, clamp saturation, pick sector
	logic [8:0]       hue_in, sat_in, hue_w, sat_c;
	logic [7:0]       int_in;
	hsi_pkg::sector_t sect_c;
	logic [8:0]       sect_base;

	assign hue_in = s_tdata[8:0];
	assign sat_in = s_tdata[17:9];
	assign int_in = s_tdata[25:18];

	always_comb begin
		hue_w = (hue_in >= 9'(hsi_pkg::FULL_TURN)) ? hue_in - 9'(hsi_pkg::FULL_TURN) : hue_in;
		sat_c = (sat_in > 9'(hsi_pkg::SAT_ONE)) ? 9'(hsi_pkg::SAT_ONE) : sat_in;
		if (hue_w >= 9'(2 * hsi_pkg::SECTOR_DEG)) begin
			sect_c = hsi_pkg::SECT_BLUE;
			sect_base = 9'(2 * hsi_pkg::SECTOR_DEG);
		end else if (hue_w >= 9'(hsi_pkg::SECTOR_DEG)) begin
			sect_c = hsi_pkg::SECT_GREEN;
			sect_base = 9'(hsi_pkg::SECTOR_DEG);
		end else begin
			sect_c = hsi_pkg::SECT_RED;
			sect_base = 9'd0;
		end
	end

	hsi_pkg::sector_t sect_s1, sect_s2, sect_s3;
	logic [6:0] off_s1;
	logic [8:0] sat_s1;
	logic [7:0] int_s1, int_s2, int_s3;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sect_s1 <= sect_c;
			off_s1  <= 7'(hue_w - sect_base);
			sat_s1  <= sat_c;
			int_s1  <= int_in;
		end
	end

	// stage 2: table read, S*ratio, I*(1-S)
	logic signed [SRW-1:0] sr_prod;
	logic [16:0]           mn_prod;
	logic signed [SRW-1:0] sr_s2;
	logic [16:0]           mn_s2;

	assign sr_prod = $signed({1'b0, sat_s1}) * ratio_rom[off_s1];
	assign mn_prod = int_s1 * (9'(hsi_pkg::SAT_ONE) - sat_s1);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			sect_s2 <= sect_s1;
			int_s2  <= int_s1;
			sr_s2   <= sr_prod;
			mn_s2   <= mn_prod;
		end
	end

	// stage 3: leading channel
	logic signed [SRW-1:0] lead_base;
	logic signed [FW-1:0]  lead_prod;
	logic signed [FW-1:0]  lead_s3, min_s3;

	assign lead_base = (SRW'(1) <<< CSH) + sr_s2;
	assign lead_prod = $signed({1'b0, int_s2}) * lead_base;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			sect_s3 <= sect_s2;
			int_s3  <= int_s2;
			lead_s3 <= lead_prod;
			min_s3  <= FW'(mn_s2) <<< RATIO_FRAC_BITS;
		end
	end

	// stage 4: third channel, clamp, route to RGB
	function automatic logic [7:0] to_chan(input logic signed [FW-1:0] fx);
		logic signed [FW-1:0] v;
		v = fx >>> CSH;
		if (fx < 0)
			return 8'd0;
		if (v > FW'(255))
			return 8'd255;
		return v[7:0];
	endfunction

	logic signed [FW-1:0] tri_fx, third_fx;
	logic [7:0]           lo_c, ld_c, th_c;
	logic [23:0]          rgb_c, rgb_s4;

	always_comb begin
		tri_fx = (FW'(int_s3) + FW'({int_s3, 1'b0})) <<< CSH;
		third_fx = tri_fx - min_s3 - lead_s3;
		lo_c = to_chan(min_s3);
		ld_c = to_chan(lead_s3);
		th_c = to_chan(third_fx);
		case (sect_s3)
			hsi_pkg::SECT_RED:   rgb_c = {lo_c, th_c, ld_c};
			hsi_pkg::SECT_GREEN: rgb_c = {th_c, ld_c, lo_c};
			hsi_pkg::SECT_BLUE:  rgb_c = {ld_c, lo_c, th_c};
			default:             rgb_c = {lo_c, th_c, ld_c};
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy4) rgb_s4 <= rgb_c;
	end

	assign m_tdata = rgb_s4;

	`ASSERT_NEXT(a_s1_to_s2, clk, arst_n, vld_s1 && rdy2, vld_s2)
	`ASSERT_NEXT(a_s3_to_out, clk, arst_n, vld_s3 && rdy4, m_tvalid)
	`ASSERT_IMPLY(a_full_stall, clk, arst_n,
		vld_s1 && vld_s2 && vld_s3 && m_tvalid && !m_tready, !s_tready)

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// HSI to RGB converter testbench
// Streams pixels through the converter under random input bursts and output
// stalls, predicts every RGB triple from a ratio table computed here, and
// compares each returned triple channel by channel in request order.
// ---------------------------------------------------------------------------
module tb;

	localparam int FRAC_BITS = hsi_pkg::RATIO_FRAC_BITS_DEF;
	localparam int RANDOM_REQUESTS = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 12;
	localparam int IDLE_LIMIT = 5000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [8:0] hue;
		logic [8:0] sat;
		logic [7:0] inten;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef enum {RX_OPEN, RX_SPARSE, RX_DENSE, RX_PERIODIC} rx_mode_t;

	class rgb_scoreboard;
		longint ratio_lut [hsi_pkg::SECTOR_DEG];
		pixel_t expected_rgb [$];
		int failures;

		function new();
			int other;
			longint num;
			longint den;
			failures = 0;
			for (int off = 0; off < hsi_pkg::SECTOR_DEG; off++) begin
				other = (off <= 60) ? (60 - off) : (off - 60);
				num = cosine_q28(off) * (longint'(1) << FRAC_BITS);
				den = cosine_q28(other);
				ratio_lut[off] = (den <= 0) ? 0 : num / den;
			end
		endfunction

		function longint cosine_q28(int deg);
			longint unsigned ang;
			longint unsigned sq;
			longint unsigned term;
			longint acc;
			ang = longint'(unsigned'(deg));
			ang = (ang * hsi_pkg::PI_Q30) / 720;
			sq = (ang * ang) >> 28;
			term = hsi_pkg::ONE_Q28;
			acc = longint'(hsi_pkg::ONE_Q28);
			for (int k = 1; k <= hsi_pkg::COS_TERMS; k++) begin
				term = (term * sq) >> 28;
				term = term / longint'((2 * k - 1) * (2 * k));
				if (k % 2 == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			return acc;
		endfunction

		function logic [7:0] clamp_channel(longint fx);
			longint v;
			if (fx < 0)
				return 8'd0;
			v = fx >>> (8 + FRAC_BITS);
			return (v > 255) ? 8'd255 : v[7:0];
		endfunction

		function pixel_t predict_rgb(logic [8:0] hue, logic [8:0] sat, logic [7:0] inten);
			pixel_t px;
			int h;
			int off;
			longint s;
			longint i;
			longint unit;
			longint min_fx;
			longint lead_fx;
			longint third_fx;
			logic [7:0] lo;
			logic [7:0] ld;
			logic [7:0] th;
			hsi_pkg::sector_t sect;
			px.hue = hue;
			px.sat = sat;
			px.inten = inten;
			h = int'(hue);
			if (h >= hsi_pkg::FULL_TURN)
				h = h - hsi_pkg::FULL_TURN;
			s = (sat > hsi_pkg::SAT_ONE) ? longint'(hsi_pkg::SAT_ONE) : longint'(sat);
			i = longint'(inten);
			if (h >= 2 * hsi_pkg::SECTOR_DEG)
				sect = hsi_pkg::SECT_BLUE;
			else if (h >= hsi_pkg::SECTOR_DEG)
				sect = hsi_pkg::SECT_GREEN;
			else
				sect = hsi_pkg::SECT_RED;
			off = h - int'(sect) * hsi_pkg::SECTOR_DEG;
			unit = longint'(hsi_pkg::SAT_ONE) * (longint'(1) << FRAC_BITS);
			min_fx = i * (hsi_pkg::SAT_ONE - s) * (longint'(1) << FRAC_BITS);
			lead_fx = i * (unit + s * ratio_lut[off]);
			third_fx = 3 * i * unit - min_fx - lead_fx;
			lo = clamp_channel(min_fx);
			ld = clamp_channel(lead_fx);
			th = clamp_channel(third_fx);
			case (sect)
				hsi_pkg::SECT_RED: begin
					px.red = ld; px.green = th; px.blue = lo;
				end
				hsi_pkg::SECT_GREEN: begin
					px.red = lo; px.green = ld; px.blue = th;
				end
				default: begin
					px.red = th; px.green = lo; px.blue = ld;
				end
			endcase
			return px;
		endfunction

		function void note_request(logic [8:0] hue, logic [8:0] sat, logic [7:0] inten);
			expected_rgb.push_back(predict_rgb(hue, sat, inten));
		endfunction

		function void check_result(logic [23:0] data);
			pixel_t px;
			if (expected_rgb.size() == 0) begin
				if (failures < MAX_REPORTS)
					$display("unexpected result rgb=%h", data);
				failures++;
				return;
			end
			px = expected_rgb.pop_front();
			if (data[7:0] !== px.red || data[15:8] !== px.green || data[23:16] !== px.blue) begin
				if (failures < MAX_REPORTS)
					$display("mismatch h=%0d s=%0d i=%0d: exp r/g/b %0d %0d %0d, got %0d %0d %0d",
						px.hue, px.sat, px.inten, px.red, px.green, px.blue,
						data[7:0], data[15:8], data[23:16]);
				failures++;
			end
		endfunction

		function int pending();
			return expected_rgb.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;   // hue_degrees[8:0], saturation[17:9], intensity[25:18]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;           // red[7:0], green[15:8], blue[23:16]

	rgb_scoreboard sb = new();
	bit long_hold_req = 1'b0;
	int burst_left = 1;
	int idle_cycles = 0;

	int unsigned dir_hue [20] = '{0, 59, 60, 61, 119, 120, 180, 239, 240, 300,
		359, 360, 419, 511, 0, 60, 119, 240, 1, 200};
	int unsigned dir_sat [20] = '{256, 256, 256, 0, 256, 257, 128, 511, 0, 256,
		256, 128, 300, 256, 256, 256, 256, 256, 256, 0};
	int unsigned dir_int [20] = '{255, 255, 255, 255, 255, 255, 200, 255, 255, 0,
		255, 128, 255, 255, 1, 128, 255, 255, 255, 0};

	hsi_to_rgb_converter #(
		.RATIO_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic send_pixel(logic [8:0] hue, logic [8:0] sat, logic [7:0] inten);
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, inten, sat, hue};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(hue, sat, inten);
	endtask

	task automatic pace_sender();
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 40);
		end
	endtask

	task automatic drain_requests();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	task automatic send_random_pixel();
		logic [8:0] hue;
		logic [8:0] sat;
		logic [7:0] inten;
		case ($urandom_range(0, 9))
			0: hue = 9'($urandom_range(360, 511));
			1: hue = 9'($urandom_range(0, 511));
			default: hue = 9'($urandom_range(0, 359));
		endcase
		case ($urandom_range(0, 9))
			0, 1: sat = 9'($urandom_range(257, 511));
			2: sat = 9'd0;
			3: sat = 9'd256;
			default: sat = 9'($urandom_range(0, 256));
		endcase
		case ($urandom_range(0, 9))
			0: inten = 8'd0;
			1: inten = 8'd255;
			default: inten = 8'($urandom_range(0, 255));
		endcase
		send_pixel(hue, sat, inten);
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		for (int n = 0; n < 20; n++) begin
			send_pixel(9'(dir_hue[n]), 9'(dir_sat[n]), 8'(dir_int[n]));
			pace_sender();
		end
		drain_requests();
		long_hold_req = 1'b1;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS / 2)
				drain_requests();
			send_random_pixel();
			pace_sender();
		end
		drain_requests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.failures += sb.pending();
		if (sb.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		rx_mode_t mode;
		int mode_left;
		int phase;
		mode = RX_OPEN;
		mode_left = 0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end
			if (mode_left <= 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			phase++;
			case (mode)
				RX_OPEN: m_tready <= 1'b1;
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) != 0);
				RX_DENSE: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (phase % 8 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/hsi_pkg.sv
hdl/hsi_to_rgb_converter.sv
verif/tb.sv
